// ----- rtl/core/mdtg_pkg.sv -----
// Package for the melody DDS tone generator.
// Opcodes, phase-step constants and the sine lookup. No dependencies.
`default_nettype none

package mdtg_pkg;

  localparam int unsigned OpW = 2;
  localparam logic [OpW-1:0] OP_SAMPLE = 2'd0;
  localparam logic [OpW-1:0] OP_FRAME  = 2'd1;
  localparam logic [OpW-1:0] OP_LOAD   = 2'd2;

  localparam int unsigned SlotW   = 6;
  localparam int unsigned FreqW   = 16;
  localparam int unsigned FramesW = 16;
  localparam int unsigned SampleW = 14;
  localparam int unsigned LenW    = 7;
  localparam int unsigned PhaseW  = 32;
  localparam int unsigned EntryW  = FreqW + FramesW;
  localparam int unsigned InDataW = 40;
  localparam int unsigned OutDataW = 16;

  localparam logic [LenW-1:0] MELODY_LEN_RST = 7'd64;

  // step = floor(freq * 2^25 / 375) = freq * 89478 + floor(freq * 182 / 375)
  localparam logic [16:0] STEP_INT  = 17'd89478;
  localparam logic [7:0]  STEP_FRAC = 8'd182;
  localparam int unsigned FracW     = 24;
  // floor(x / 375) = (x * RECIP_M) >> RECIP_SHIFT for x < 2^24
  localparam logic [25:0] RECIP_M     = 26'd45812985;
  localparam int unsigned RecipShift  = 34;
  localparam int unsigned RecipProdW  = 50;

  localparam int unsigned MagW = 13;
  localparam logic [MagW-1:0] QUARTER_WAVE [65] = '{
    13'd0,    13'd147,  13'd294,  13'd441,  13'd588,  13'd734,  13'd880,  13'd1025,
    13'd1170, 13'd1314, 13'd1457, 13'd1600, 13'd1741, 13'd1882, 13'd2021, 13'd2159,
    13'd2296, 13'd2431, 13'd2565, 13'd2697, 13'd2828, 13'd2957, 13'd3084, 13'd3209,
    13'd3333, 13'd3454, 13'd3574, 13'd3691, 13'd3806, 13'd3919, 13'd4029, 13'd4137,
    13'd4242, 13'd4345, 13'd4445, 13'd4543, 13'd4638, 13'd4730, 13'd4819, 13'd4905,
    13'd4988, 13'd5069, 13'd5146, 13'd5220, 13'd5291, 13'd5359, 13'd5423, 13'd5485,
    13'd5543, 13'd5597, 13'd5649, 13'd5697, 13'd5741, 13'd5782, 13'd5820, 13'd5854,
    13'd5884, 13'd5911, 13'd5935, 13'd5954, 13'd5971, 13'd5983, 13'd5992, 13'd5998,
    13'd6000
  };

  function automatic logic signed [SampleW-1:0] sine_lookup(input logic [7:0] idx);
    logic [6:0]       half;
    logic [6:0]       qi;
    logic [MagW-1:0]  mag;
    logic [SampleW-1:0] mag_ext;
    half = idx[6:0];
    qi   = (half <= 7'd64) ? half : (7'd0 - half);  // 128 - half, mod 128
    mag  = QUARTER_WAVE[qi];
    mag_ext = SampleW'(mag);
    sine_lookup = idx[7] ? $signed(-mag_ext) : $signed(mag_ext);
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/melody_dds_tone_generator.sv -----
// Melody DDS tone generator top level: note table RAM, note sequencer, phase
// accumulator and sine output. Depends on mdtg_pkg.
`default_nettype none

// Takes one transfer per cycle while tready is high; tready is low while an
// output sample waits on m_axis_tready and during the updates below. tdata
// carries op, note_slot, note_freq and note_frames; a sample tick yields one
// 14-bit signed sample through an output register, frame ticks and note loads
// yield nothing. A frame tick ending the current note reads the next entry
// from the note table RAM and computes the new phase step in a two-stage
// multiply, tready low until it is written. A melody_length write re-reduces
// the position with a one-bit-per-cycle modulo unit, tready low until done.
// No clearing pass: the user must load entries before reading; not enforced.
module melody_dds_tone_generator
  import mdtg_pkg::*;
#(
  parameter int unsigned MAX_NOTES = 64
) (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     cfg_we_i,
  input  wire  [LenW-1:0]         cfg_wdata_i,     // melody_length
  input  wire                     s_axis_tvalid,
  output logic                    s_axis_tready,
  // [1:0] op, [7:2] note_slot, [23:8] note_freq, [39:24] note_frames
  input  wire  [InDataW-1:0]      s_axis_tdata,
  output logic                    m_axis_tvalid,
  input  wire                     m_axis_tready,
  // [13:0] sample, [15:14] zero
  output logic [OutDataW-1:0]     m_axis_tdata
);

  localparam int unsigned AW = (MAX_NOTES > 1) ? $clog2(MAX_NOTES) : 1;
  localparam int unsigned PW = $clog2(MAX_NOTES + 1);
  localparam int unsigned CW = $clog2(PW + 1);
  localparam int unsigned IW = (PW > 1) ? $clog2(PW) : 1;

  logic [OpW-1:0]     in_op;
  logic [SlotW-1:0]   in_slot;
  logic [FreqW-1:0]   in_freq;
  logic [FramesW-1:0] in_frames;
  logic               in_acc;
  logic               slot_ok;
  logic               note_end;

  assign in_op     = s_axis_tdata[1:0];
  assign in_slot   = s_axis_tdata[7:2];
  assign in_freq   = s_axis_tdata[23:8];
  assign in_frames = s_axis_tdata[39:24];
  assign in_acc    = s_axis_tvalid && s_axis_tready;

  logic [LenW-1:0]    mel_len_q;
  logic [PhaseW-1:0]  phase_q;
  logic [PhaseW-1:0]  step_q;
  logic [AW-1:0]      pos_q;
  logic [AW-1:0]      next_pos_q;
  logic [FramesW-1:0] frames_q;
  logic               s1_q, s2_q;
  logic               busy_q;
  logic [CW-1:0]      cnt_q;
  logic [PW-1:0]      rem_q;
  logic               out_valid_q;
  logic signed [SampleW-1:0] out_sample_q;

  logic [EntryW-1:0]  note_mem [MAX_NOTES];
  logic [EntryW-1:0]  rd_q;
  logic [PhaseW-1:0]  p1_q;
  logic [FracW-1:0]   x_q;

  logic [PW-1:0] eff_len;
  always_comb begin
    if (mel_len_q == '0) begin
      eff_len = PW'(1);
    end else if (32'(mel_len_q) > 32'(MAX_NOTES)) begin
      eff_len = PW'(MAX_NOTES);
    end else begin
      eff_len = PW'(mel_len_q);
    end
  end

  assign slot_ok  = 32'(in_slot) < 32'(MAX_NOTES);
  assign note_end = in_acc && (in_op == OP_FRAME) && (frames_q <= FramesW'(1));

  assign s_axis_tready = !(s1_q || s2_q || busy_q) && (!out_valid_q || m_axis_tready);

  // position that follows the new note
  logic [PW-1:0] nn;
  logic [AW-1:0] next_after;
  assign nn         = PW'(next_pos_q) + PW'(1);
  assign next_after = (nn >= eff_len) ? '0 : AW'(nn);

  // modulo unit: (pos + 1) mod eff_len, restoring, one bit a cycle
  logic [PW-1:0] dividend;
  logic [IW-1:0] bit_idx;
  logic [PW:0]   rem_sh;
  logic [PW:0]   rem_nx;
  assign dividend = PW'(pos_q) + PW'(1);
  assign bit_idx  = IW'(cnt_q - CW'(1));
  assign rem_sh   = {rem_q, dividend[bit_idx]};
  assign rem_nx   = (rem_sh >= {1'b0, eff_len}) ? (rem_sh - {1'b0, eff_len}) : rem_sh;

  // note table RAM
  always_ff @(posedge clk_i) begin
    if (in_acc && (in_op == OP_LOAD) && slot_ok) begin
      note_mem[AW'(in_slot)] <= {in_frames, in_freq};
    end
    if (note_end) begin
      rd_q <= note_mem[next_pos_q];
    end
  end

  // phase step datapath
  logic [32:0]           prod_int;
  logic [RecipProdW-1:0] prod_recip;
  assign prod_int   = 33'(rd_q[FreqW-1:0]) * 33'(STEP_INT);
  assign prod_recip = RecipProdW'(x_q) * RecipProdW'(RECIP_M);

  always_ff @(posedge clk_i) begin
    p1_q <= prod_int[PhaseW-1:0];
    x_q  <= FracW'(rd_q[FreqW-1:0]) * FracW'(STEP_FRAC);
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && (in_op == OP_SAMPLE)) begin
      out_sample_q <= (step_q != '0) ? sine_lookup(phase_q[31:24]) : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mel_len_q   <= MELODY_LEN_RST;
      phase_q     <= '0;
      step_q      <= '0;
      pos_q       <= '0;
      next_pos_q  <= AW'(1);
      frames_q    <= '0;
      s1_q        <= 1'b0;
      s2_q        <= 1'b0;
      busy_q      <= 1'b0;
      cnt_q       <= '0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      s1_q <= note_end;
      s2_q <= s1_q;
      if (s1_q) begin
        frames_q <= rd_q[EntryW-1:FreqW];
      end
      if (s2_q) begin
        step_q <= p1_q + PhaseW'(prod_recip[RecipProdW-1:RecipShift]);
      end

      if (cfg_we_i) begin
        mel_len_q <= cfg_wdata_i;
        busy_q    <= 1'b1;
        cnt_q     <= CW'(PW);
        rem_q     <= '0;
      end else if (busy_q) begin
        rem_q <= rem_nx[PW-1:0];
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q     <= 1'b0;
          next_pos_q <= AW'(rem_nx);
        end
      end

      if (out_valid_q && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end

      if (in_acc) begin
        case (in_op)
          OP_SAMPLE: begin
            out_valid_q <= 1'b1;
            if (step_q != '0) begin
              phase_q <= phase_q + step_q;
            end
          end
          OP_FRAME: begin
            if (frames_q > FramesW'(1)) begin
              frames_q <= frames_q - FramesW'(1);
            end else begin
              pos_q      <= next_pos_q;
              next_pos_q <= next_after;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutDataW - SampleW){1'b0}}, out_sample_q};

endmodule

`default_nettype wire

// ----- sim/melody_dds_tone_generator_tb.sv -----
// Self-checking testbench for melody_dds_tone_generator: note loads, frame and
// sample ticks, melody length writes, random idling and a long output hold-off.
// Depends on mdtg_pkg and the melody_dds_tone_generator RTL.
`default_nettype none

module melody_dds_tone_generator_tb;
  import mdtg_pkg::*;

  localparam int unsigned NoteSlots = 64;
  localparam longint unsigned SampleRateHz = 48000;
  localparam logic [OpW-1:0] OP_NONE = 2'd3;
  localparam int CycleLimit = 200000;
  localparam int DrainCycles = 16;
  localparam int HoldCycles = 300;

  typedef struct packed {
    logic [FramesW-1:0] frames;
    logic [FreqW-1:0]   freq;
    logic [SlotW-1:0]   slot;
    logic [OpW-1:0]     op;
  } tone_cmd_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_we = 1'b0;
  logic [LenW-1:0]     cfg_wdata = '0;
  logic                s_valid = 1'b0;
  logic                s_ready;
  logic [InDataW-1:0]  s_data = '0;
  logic                m_valid;
  logic                m_ready = 1'b0;
  logic [OutDataW-1:0] m_data;

  melody_dds_tone_generator #(.MAX_NOTES(NoteSlots)) DUT (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .s_axis_tvalid(s_valid),
    .s_axis_tready(s_ready),
    .s_axis_tdata (s_data),
    .m_axis_tvalid(m_valid),
    .m_axis_tready(m_ready),
    .m_axis_tdata (m_data)
  );

  int unsigned quarter_mag [0:64] = '{
       0,  147,  294,  441,  588,  734,  880, 1025,
    1170, 1314, 1457, 1600, 1741, 1882, 2021, 2159,
    2296, 2431, 2565, 2697, 2828, 2957, 3084, 3209,
    3333, 3454, 3574, 3691, 3806, 3919, 4029, 4137,
    4242, 4345, 4445, 4543, 4638, 4730, 4819, 4905,
    4988, 5069, 5146, 5220, 5291, 5359, 5423, 5485,
    5543, 5597, 5649, 5697, 5741, 5782, 5820, 5854,
    5884, 5911, 5935, 5954, 5971, 5983, 5992, 5998,
    6000
  };

  // tone state mirrored from the block
  logic [PhaseW-1:0]  acc_q = '0;
  logic [PhaseW-1:0]  step_q = '0;
  int unsigned        note_pos_q = 0;
  logic [FramesW-1:0] frames_left_q = '0;
  logic [EntryW-1:0]  note_mem [NoteSlots];
  bit                 note_loaded [NoteSlots] = '{default: 1'b0};
  logic [LenW-1:0]    melody_len = MELODY_LEN_RST;

  logic [OutDataW-1:0] sample_fifo [$];
  logic [OutDataW-1:0] want_sample;

  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int hold_req_cnt = 0;
  int hold_ack_cnt = 0;
  int hold_left = 0;
  int cycles = 0;
  int errors = 0;
  int n_checked = 0;
  int n_frames = 0;
  int n_notes = 0;
  int n_loads = 0;
  int n_junk = 0;
  int n_cfg = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d samples outstanding", cycles, sample_fifo.size());
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (hold_req_cnt != hold_ack_cnt) begin
      hold_ack_cnt <= hold_req_cnt;
      hold_left    <= HoldCycles;
      m_ready      <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_ready   <= 1'b0;
    end else begin
      m_ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && m_valid && m_ready) begin
      if (sample_fifo.size() == 0) begin
        errors++;
        $display("%0t: unexpected sample transfer, expected none, got %h", $time, m_data);
      end else begin
        want_sample = sample_fifo.pop_front();
        n_checked++;
        if (m_data !== want_sample) begin
          errors++;
          $display("%0t: sample mismatch, expected %h, got %h", $time, want_sample, m_data);
        end
      end
    end
  end

  function automatic logic [SampleW-1:0] wave_at(input logic [7:0] k);
    int unsigned half;
    int          mag;
    half = k[6:0];
    mag  = (half <= 64) ? quarter_mag[half] : quarter_mag[128 - half];
    if (k[7]) mag = -mag;
    return mag[SampleW-1:0];
  endfunction

  function automatic logic [PhaseW-1:0] step_for(input logic [FreqW-1:0] f);
    logic [63:0] num;
    num = {f, 32'd0};
    return PhaseW'(num / SampleRateHz);
  endfunction

  function automatic int unsigned eff_len();
    int unsigned n;
    n = melody_len;
    if (n == 0) n = 1;
    if (n > NoteSlots) n = NoteSlots;
    return n;
  endfunction

  function automatic int unsigned next_pos();
    return (note_pos_q + 1) % eff_len();
  endfunction

  function automatic bit frame_reads_blank();
    return frames_left_q <= 1 && !note_loaded[next_pos()];
  endfunction

  function automatic tone_cmd_t cmd(input logic [OpW-1:0] op, input int unsigned slot,
                                    input int unsigned freq, input int unsigned frames);
    return '{frames: FramesW'(frames), freq: FreqW'(freq), slot: SlotW'(slot), op: op};
  endfunction

  function automatic int unsigned pick_freq();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 15) return 0;
    if (r < 20) return 48000;
    if (r < 35) return $urandom_range(0, 65535);
    return $urandom_range(20, 8000);
  endfunction

  task automatic predict_tone(input tone_cmd_t c);
    logic [SampleW-1:0] s;
    logic [FreqW-1:0]   f;
    case (c.op)
      OP_SAMPLE: begin
        s = '0;
        if (step_q != 0) begin
          s = wave_at(acc_q[PhaseW-1 -: 8]);
          acc_q += step_q;
        end
        sample_fifo.push_back(OutDataW'(s));
      end
      OP_FRAME: begin
        n_frames++;
        if (frames_left_q > 1) begin
          frames_left_q--;
        end else begin
          note_pos_q = next_pos();
          {frames_left_q, f} = note_mem[note_pos_q];
          step_q = step_for(f);
          n_notes++;
        end
      end
      OP_LOAD: begin
        note_mem[c.slot]    = {c.frames, c.freq};
        note_loaded[c.slot] = 1'b1;
        n_loads++;
      end
      default: n_junk++;
    endcase
  endtask

  task automatic send_cmd(input tone_cmd_t c);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_valid <= 1'b0;
      @(posedge clk);
    end
    s_valid <= 1'b1;
    s_data  <= c;
    do @(posedge clk); while (!s_ready);
    predict_tone(c);
  endtask

  task automatic quiesce();
    s_valid <= 1'b0;
    while (sample_fifo.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic set_length(input logic [LenW-1:0] len);
    quiesce();
    cfg_we    <= 1'b1;
    cfg_wdata <= len;
    @(posedge clk);
    cfg_we     <= 1'b0;
    melody_len = len;
    n_cfg++;
  endtask

  task automatic normal_load(input int unsigned slot);
    send_cmd(cmd(OP_LOAD, slot, pick_freq(), $urandom_range(0, 3)));
  endtask

  task automatic send_random();
    tone_cmd_t   c;
    int unsigned r;
    int unsigned slot;
    c = InDataW'({$urandom, $urandom});
    r = $urandom_range(99);
    if (r < 48) begin
      c.op = OP_SAMPLE;
      send_cmd(c);
    end else if (r < 72) begin
      if (frame_reads_blank()) begin
        normal_load(next_pos());
      end else begin
        c.op = OP_FRAME;
        send_cmd(c);
      end
    end else if (r < 94) begin
      slot = ($urandom_range(9) < 7) ? $urandom_range(0, eff_len() - 1) : $urandom_range(0, 63);
      normal_load(slot);
    end else if (r < 97) begin
      // wide-range entry, rewritten before it can be played
      c.op = OP_LOAD;
      send_cmd(c);
      normal_load(c.slot);
    end else begin
      c.op = OP_NONE;
      send_cmd(c);
    end
  endtask

  task automatic test_directed();
    tx_idle_pct  = 0;
    rx_stall_pct <= 0;
    send_cmd(cmd(OP_SAMPLE, 0, 0, 0));
    send_cmd(cmd(OP_NONE, 63, 16'hFFFF, 16'hFFFF));
    send_cmd(cmd(OP_LOAD, 1, 1000, 2));
    send_cmd(cmd(OP_LOAD, 2, 48000, 0));
    send_cmd(cmd(OP_LOAD, 3, 65535, 1));
    send_cmd(cmd(OP_LOAD, 0, 1, 0));
    send_cmd(cmd(OP_LOAD, 63, 0, 16'hFFFF));
    send_cmd(cmd(OP_LOAD, 63, 440, 3));
    set_length(7'd4);
    send_cmd(cmd(OP_FRAME, 0, 0, 0));
    repeat (3) send_cmd(cmd(OP_SAMPLE, 0, 0, 0));
    send_cmd(cmd(OP_FRAME, 0, 0, 0));
    send_cmd(cmd(OP_FRAME, 0, 0, 0));
    send_cmd(cmd(OP_SAMPLE, 0, 0, 0));
    send_cmd(cmd(OP_FRAME, 0, 0, 0));
    repeat (2) send_cmd(cmd(OP_SAMPLE, 0, 0, 0));
    send_cmd(cmd(OP_FRAME, 0, 0, 0));
    send_cmd(cmd(OP_SAMPLE, 0, 0, 0));
  endtask

  task automatic test_random(input int n, input int tx_pct, input int rx_pct,
                             input logic [LenW-1:0] len);
    set_length(len);
    tx_idle_pct  = tx_pct;
    rx_stall_pct <= rx_pct;
    repeat (n) send_random();
  endtask

  task automatic test_backpressure();
    set_length(MELODY_LEN_RST);
    tx_idle_pct  = 0;
    rx_stall_pct <= 0;
    hold_req_cnt <= hold_req_cnt + 1;
    repeat (80) send_random();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(400, 0, 0, 7'd127);
    test_random(400, 52, 0, 7'($urandom_range(2, 63)));
    test_random(400, 0, 52, 7'($urandom_range(65, 126)));
    test_random(250, 7, 7, 7'd0);
    test_random(150, 7, 7, 7'd1);
    test_backpressure();
    quiesce();
    $display("tb: %0d samples checked, %0d frame ticks with %0d note changes, %0d loads, %0d ignored",
             n_checked, n_frames, n_notes, n_loads, n_junk);
    $display("tb: %0d melody length writes, idle and stall mixes, one long output hold-off",
             n_cfg);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- files.f -----
rtl/core/mdtg_pkg.sv
rtl/core/melody_dds_tone_generator.sv
sim/melody_dds_tone_generator_tb.sv
